>>> hw/rtl/png_row_unfilter_unit_assert.svh
// Assertion macros shared by the row unfilter RTL.
`ifndef PNG_ROW_UNFILTER_UNIT_ASSERT_SVH
`define PNG_ROW_UNFILTER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define PRU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pru assertion failed");

// Next-cycle implication, disabled during reset
`define PRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pru assertion failed");

`endif

>>> hw/rtl/pru_pkg.sv
// Package for the PNG row unfilter: sizes, codes and the Paeth predictor.
package pru_pkg;

   // Row store sizing
   localparam int MAX_ROW_BYTES = 8192;
   localparam int POS_W         = $clog2(MAX_ROW_BYTES);
   localparam int LEN_W         = POS_W + 1;

   // Register fields
   localparam int BPP_W     = 4;
   localparam int ROW_LEN_W = 14;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 14;
   localparam int CMP_W     = (ROW_LEN_W > LEN_W) ? ROW_LEN_W : LEN_W;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BPP     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ROW_LEN = 1'd1;

   // Register reset values
   localparam logic [BPP_W-1:0]     BPP_RESET     = 4'd4;
   localparam logic [ROW_LEN_W-1:0] ROW_LEN_RESET = 14'd1024;

   // Filter type codes
   localparam logic [2:0] FILT_NONE  = 3'd0;
   localparam logic [2:0] FILT_SUB   = 3'd1;
   localparam logic [2:0] FILT_UP    = 3'd2;
   localparam logic [2:0] FILT_AVG   = 3'd3;
   localparam logic [2:0] FILT_PAETH = 3'd4;

   // History depth (pixels up to eight bytes)
   localparam int HIST_DEPTH = 8;
   localparam int HIST_IDX_W = $clog2(HIST_DEPTH);

   // Beat held between the read issue and the reconstruct step
   typedef struct packed {
      logic [7:0]            x;
      logic [2:0]            filter;
      logic                  first;
      logic [POS_W-1:0]      pos;
      logic                  has_left;
      logic [HIST_IDX_W-1:0] left_idx;
      logic                  last;
      logic                  fwd;
      logic [7:0]            fwd_data;
   } stage_type;

   // Paeth predictor: pick the neighbour closest to a + b - c
   function automatic logic [7:0] paeth_predict(input logic [7:0] a,
                                                input logic [7:0] b,
                                                input logic [7:0] c);
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic [9:0]        pa;
      logic [9:0]        pb;
      logic [9:0]        pc;
      logic [7:0]        pick;
      da = $signed({2'b00, b}) - $signed({2'b00, c});
      db = $signed({2'b00, a}) - $signed({2'b00, c});
      dc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
      pa = (da < 0) ? 10'(-da) : 10'(da);
      pb = (db < 0) ? 10'(-db) : 10'(db);
      pc = (dc < 0) ? 10'(-dc) : 10'(dc);
      if ((pa <= pb) && (pa <= pc)) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

>>> hw/rtl/png_row_unfilter_unit.sv
// PNG scanline unfilter top level: row store, neighbour history and output register.
//
//  channel | dir | ports                           | carries
//  --------+-----+---------------------------------+-------------------------------------
//  req     | in  | req_tvalid/tready/tdata/tuser   | filtered byte, filter type, first row
//  rsp     | out | rsp_tvalid/tready/tdata/tuser/  | raw byte, bad filter, row end
//          |     | tlast                           |
//  csr     | in  | csr_wr_en/index/wr_data         | bytes per pixel, row length
//
// One byte per cycle sustained while rsp does not stall; a beat passes through the
// reconstruct stage register and then the output register before rsp_tvalid rises.
// The accept edge issues the row store read at the byte position; the reconstruct stage
// then forms the prediction and, at commit, writes the result to the store, history and output.
// A same-address write during the read is forwarded, so one-byte rows keep full rate.
// Synchronous reset; the row store is not cleared, its contents stay undefined
// until the first row writes them.
// A stall on rsp holds the output register and the reconstruct stage; req_tready
// falls once both are full.
module png_row_unfilter_unit (
   input  logic                           clock,
   input  logic                           reset,
   // req_tdata: [7:0] filtered_byte
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [7:0]                     req_tdata,
   // req_tuser: [2:0] filter_type, [3] first_row
   input  logic [3:0]                     req_tuser,
   // rsp_tdata: [7:0] pixel_byte
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [7:0]                     rsp_tdata,
   // rsp_tuser: [0] bad_filter
   output logic [0:0]                     rsp_tuser,
   output logic                           rsp_tlast,
   input  logic                           csr_wr_en,
   input  logic [pru_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [pru_pkg::CSR_DAT_W-1:0]  csr_wr_data
);

   import pru_pkg::*;

   `include "png_row_unfilter_unit_assert.svh"

   // Configuration registers
   logic [BPP_W-1:0]     bpp_ff;
   logic [ROW_LEN_W-1:0] row_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff     <= BPP_RESET;
         row_len_ff <= ROW_LEN_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_BPP:     bpp_ff     <= csr_wr_data[BPP_W-1:0];
            REG_ROW_LEN: row_len_ff <= csr_wr_data[ROW_LEN_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamp pixel size to 1..8 and row length to 1..MAX_ROW_BYTES
   logic [BPP_W-1:0] bpp_eff;
   logic [CMP_W-1:0] len_wide;
   logic [LEN_W-1:0] len_eff;

   always_comb begin
      if (bpp_ff == '0) begin
         bpp_eff = BPP_W'(1);
      end else if (bpp_ff > BPP_W'(HIST_DEPTH)) begin
         bpp_eff = BPP_W'(HIST_DEPTH);
      end else begin
         bpp_eff = bpp_ff;
      end
      len_wide = CMP_W'(row_len_ff);
      if (len_wide == '0) begin
         len_eff = LEN_W'(1);
      end else if (len_wide > CMP_W'(MAX_ROW_BYTES)) begin
         len_eff = LEN_W'(MAX_ROW_BYTES);
      end else begin
         len_eff = len_wide[LEN_W-1:0];
      end
   end

   // Pipeline control
   stage_type s1_ff;
   logic      s1_valid_ff;
   logic      out_valid_ff;
   logic [7:0] out_byte_ff;
   logic       out_bad_ff;
   logic       out_last_ff;
   logic       commit;
   logic       accept;

   assign commit     = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || commit;
   assign accept     = req_tvalid && req_tready;

   // Stage 0: byte position, row latches and store read
   logic [POS_W-1:0]      pos_ff;
   logic [2:0]            row_filter_ff;
   logic                  row_first_ff;
   logic [LEN_W-1:0]      pos_inc;
   logic                  in_last;
   logic                  at_start;
   logic [2:0]            in_filter;
   logic                  in_first;
   logic                  in_has_left;
   logic [HIST_IDX_W-1:0] in_left_idx;
   logic                  fwd_hit;

   assign pos_inc     = {1'b0, pos_ff} + LEN_W'(1);
   assign in_last     = (pos_inc >= len_eff);
   assign at_start    = (pos_ff == '0);
   assign in_filter   = at_start ? req_tuser[2:0] : row_filter_ff;
   assign in_first    = at_start ? req_tuser[3] : row_first_ff;
   assign in_has_left = (pos_ff >= POS_W'(bpp_eff));
   assign in_left_idx = pos_ff[HIST_IDX_W-1:0] - bpp_eff[HIST_IDX_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= '0;
         row_filter_ff <= FILT_NONE;
         row_first_ff  <= 1'b1;
      end else if (accept) begin
         pos_ff <= in_last ? '0 : pos_inc[POS_W-1:0];
         if (at_start) begin
            row_filter_ff <= req_tuser[2:0];
            row_first_ff  <= req_tuser[3];
         end
      end
   end

   // Row store: read at accept, written back at commit
   logic [7:0] store_rd;
   logic [7:0] result;

   pru_ram #(
      .WIDTH (8),
      .DEPTH (MAX_ROW_BYTES)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (commit),
      .wr_addr (s1_ff.pos),
      .wr_data (result),
      .rd_en   (accept),
      .rd_addr (pos_ff),
      .rd_data (store_rd)
   );

   // A write to the address being read in the same cycle is forwarded
   assign fwd_hit = commit && (s1_ff.pos == pos_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (commit) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ff.x        <= req_tdata;
         s1_ff.filter   <= in_filter;
         s1_ff.first    <= in_first;
         s1_ff.pos      <= pos_ff;
         s1_ff.has_left <= in_has_left;
         s1_ff.left_idx <= in_left_idx;
         s1_ff.last     <= in_last;
         s1_ff.fwd      <= fwd_hit;
         s1_ff.fwd_data <= result;
      end
   end

   // Stage 1: neighbours, prediction and reconstruction
   logic [7:0] left_hist_ff   [HIST_DEPTH];
   logic [7:0] upleft_hist_ff [HIST_DEPTH];
   logic [7:0] nb_a;
   logic [7:0] nb_b;
   logic [7:0] nb_c;
   logic [8:0] avg_sum;
   logic [7:0] pred;
   logic       bad;

   always_comb begin
      if (s1_ff.first) begin
         nb_b = 8'd0;
      end else if (s1_ff.fwd) begin
         nb_b = s1_ff.fwd_data;
      end else begin
         nb_b = store_rd;
      end
      nb_a    = s1_ff.has_left ? left_hist_ff[s1_ff.left_idx]   : 8'd0;
      nb_c    = s1_ff.has_left ? upleft_hist_ff[s1_ff.left_idx] : 8'd0;
      avg_sum = {1'b0, nb_a} + {1'b0, nb_b};
      bad     = 1'b0;
      case (s1_ff.filter)
         FILT_NONE:  pred = 8'd0;
         FILT_SUB:   pred = nb_a;
         FILT_UP:    pred = nb_b;
         FILT_AVG:   pred = avg_sum[8:1];
         FILT_PAETH: pred = paeth_predict(nb_a, nb_b, nb_c);
         default: begin
            pred = 8'd0;
            bad  = 1'b1;
         end
      endcase
      result = s1_ff.x + pred;
   end

   // History of the last eight results and up bytes
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            left_hist_ff[i]   <= 8'd0;
            upleft_hist_ff[i] <= 8'd0;
         end
      end else if (commit) begin
         left_hist_ff[s1_ff.pos[HIST_IDX_W-1:0]]   <= result;
         upleft_hist_ff[s1_ff.pos[HIST_IDX_W-1:0]] <= nb_b;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (commit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         out_byte_ff <= result;
         out_bad_ff  <= bad;
         out_last_ff <= s1_ff.last;
      end
   end

   assign rsp_tvalid   = out_valid_ff;
   assign rsp_tdata    = out_byte_ff;
   assign rsp_tuser[0] = out_bad_ff;
   assign rsp_tlast    = out_last_ff;

   // Checks
   `PRU_ASSERT_NOW(a_stall_blocks_req, clock, reset, s1_valid_ff && !commit, !req_tready)
   `PRU_ASSERT_NEXT(a_row_end_wraps, clock, reset, accept && in_last, pos_ff == '0)
   `PRU_ASSERT_NEXT(a_commit_loads_out, clock, reset, commit, rsp_tvalid)
   `PRU_ASSERT_NEXT(a_fwd_same_addr, clock, reset, accept && fwd_hit,
                    s1_ff.fwd && (s1_ff.pos == $past(s1_ff.pos)))

endmodule

>>> hw/rtl/pru_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pru_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
